// ===== hw/rtl/sorted_table_engine_unit_defines.svh =====
// Assertion macros shared by the sorted table engine checkers.
// No dependencies; include by bare file name.
`ifndef SORTED_TABLE_ENGINE_UNIT_DEFINES_SVH
`define SORTED_TABLE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/ste_pkg.sv =====
// Shared types and codes for the sorted table engine.
// No dependencies.
`default_nettype none

package ste_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // One finished result beat, at the fixed port widths.
    typedef struct packed {
        t_status            status;
        logic [7:0]         found_index;
        logic [7:0]         fill_count;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_table_engine_unit.sv =====
// Top level of the sorted table engine: sequencer, entry store, result register.
// Depends on ste_pkg, ste_mem and ste_ctrl.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   request   | i_valid / o_ready    | i_op, i_value
//   result    | o_valid / i_ready    | o_status, o_found_index, o_fill_count,
//             |                      | o_smallest, o_largest
//
// Passes: insert, delete and search scan the stored entries, while clear and
// rejected requests do not. A pass is paced by the single read port of the
// entry store: each pass touches one entry per cycle.
// Reset: i_rst_n low at a clock edge empties the table and drops o_valid; the
// entry store itself is not cleared, entries past the fill count are ignored.
// Stalls: a finished beat waits in the result register while the next request
// is taken; the sequencer holds its own result only if that register is full.
`default_nettype none

module sorted_table_engine_unit
    import ste_pkg::*;
#(
    parameter int CAPACITY      = 128,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic [7:0]              o_found_index,
    output logic [7:0]              o_fill_count,
    output logic signed [31:0]      o_smallest,
    output logic signed [31:0]      o_largest
);

    localparam int AW = $clog2(CAPACITY);

    logic                     w_res_valid;
    logic                     w_res_take;
    t_result                  w_res;
    logic                     w_mem_we;
    logic [AW-1:0]            w_mem_waddr;
    logic [ELEMENT_WIDTH-1:0] w_mem_wdata;
    logic                     w_mem_re;
    logic [AW-1:0]            w_mem_raddr;
    logic [ELEMENT_WIDTH-1:0] w_mem_rdata;

    logic                     r_out_valid;
    t_result                  r_out;

    ste_ctrl #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    ste_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEMENT_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // result register loads when empty or being drained this cycle
    assign w_res_take = w_res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_index = r_out.found_index;
    assign o_fill_count  = r_out.fill_count;
    assign o_smallest    = r_out.smallest;
    assign o_largest     = r_out.largest;

endmodule

`default_nettype wire

// ===== hw/rtl/ste_mem.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module ste_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-old on a same-address collision; the sequencer never relies on it
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/ste_ctrl.sv =====
// Sequencer: scans and shifts the entry store one entry per cycle.
// Depends on ste_pkg; drives ste_mem.
`default_nettype none

module ste_ctrl
    import ste_pkg::*;
#(
    parameter int CAPACITY      = 128,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [1:0]                          i_op,
    input  wire logic signed [31:0]                  i_value,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_take,
    output t_result                                  o_res,
    output logic                                     o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]              o_mem_waddr,
    output logic [ELEMENT_WIDTH-1:0]                 o_mem_wdata,
    output logic                                     o_mem_re,
    output logic [$clog2(CAPACITY)-1:0]              o_mem_raddr,
    input  wire logic [ELEMENT_WIDTH-1:0]            i_mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ELEMENT_WIDTH;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INS  = 8'b0000_0010,
        S_PUT  = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_LO   = 8'b0001_0000,
        S_HI   = 8'b0010_0000,
        S_CAP  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    t_op                  r_op, n_op;
    logic signed [EW-1:0] r_val, n_val;
    logic [CW-1:0]        r_k, n_k;        // next address to read
    logic                 r_more, n_more;  // reads left to issue
    logic                 r_pend, n_pend;  // read data arrives this cycle
    logic [CW-1:0]        r_j, n_j;        // address of arriving data
    logic                 r_found, n_found;
    logic [CW-1:0]        r_pos, n_pos;
    t_status              r_status, n_status;
    logic [CW-1:0]        r_index, n_index;
    logic [EW-1:0]        r_lo, n_lo;
    logic [EW-1:0]        r_hi, n_hi;

    logic [EW+31:0]       w_v_ext;
    logic signed [EW-1:0] w_v;
    logic signed [EW-1:0] w_rd;
    logic [CW-1:0]        w_j_up;
    logic [CW-1:0]        w_j_dn;
    logic [CW-1:0]        w_cnt_m1;
    logic                 w_last;
    logic [EW+31:0]       w_lo_ext;
    logic [EW+31:0]       w_hi_ext;
    logic [CW+7:0]        w_idx_ext;
    logic [CW+7:0]        w_cnt_ext;

    // 32-bit field, sign-extended, then narrowed to the element width
    assign w_v_ext  = {{EW{i_value[31]}}, i_value};
    assign w_v      = w_v_ext[EW-1:0];
    assign w_rd     = i_mem_rdata;
    assign w_j_up   = r_j + CW'(1);
    assign w_j_dn   = r_j - CW'(1);
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_last   = (r_j == w_cnt_m1);

    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_k         = r_k;
        n_more      = r_more;
        n_pend      = 1'b0;
        n_j         = r_j;
        n_found     = r_found;
        n_pos       = r_pos;
        n_status    = r_status;
        n_index     = r_index;
        n_lo        = r_lo;
        n_hi        = r_hi;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos[AW-1:0];
        o_mem_wdata = r_val;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_k[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = t_op'(i_op);
                    n_val    = w_v;
                    n_status = ST_DONE;
                    n_index  = '0;
                    n_found  = 1'b0;
                    n_more   = 1'b1;
                    n_pos    = '0;
                    case (t_op'(i_op))
                        OP_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_LO;
                            end else if (r_count == '0) begin
                                n_state = S_PUT;
                            end else begin
                                n_k     = w_cnt_m1;
                                n_state = S_INS;
                            end
                        end
                        OP_DELETE, OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_LO;
                            end else begin
                                n_k     = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_state = S_LO;
                        end
                    endcase
                end
            end

            // top-down pass: shift larger entries up one, stop at the slot
            S_INS: begin
                o_mem_re = r_more;
                if (r_more) begin
                    n_pend = 1'b1;
                    n_j    = r_k;
                    if (r_k == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_k = r_k - CW'(1);
                    end
                end
                if (r_pend) begin
                    if (w_rd > r_val) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = w_j_up[AW-1:0];
                        o_mem_wdata = i_mem_rdata;
                        if (r_j == '0) begin
                            n_pos   = '0;
                            n_pend  = 1'b0;
                            n_state = S_PUT;
                        end
                    end else begin
                        n_pos   = w_j_up;
                        n_pend  = 1'b0;
                        n_state = S_PUT;
                    end
                end
            end

            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos[AW-1:0];
                o_mem_wdata = r_val;
                n_count     = r_count + CW'(1);
                n_index     = r_pos + CW'(1);
                n_state     = S_LO;
            end

            // bottom-up pass: find the first match; delete then pulls the
            // rest down one place
            S_SCAN: begin
                o_mem_re = r_more;
                if (r_more) begin
                    n_pend = 1'b1;
                    n_j    = r_k;
                    if (r_k == w_cnt_m1) begin
                        n_more = 1'b0;
                    end else begin
                        n_k = r_k + CW'(1);
                    end
                end
                if (r_pend) begin
                    if (!r_found) begin
                        if (w_rd == r_val) begin
                            n_found = 1'b1;
                            n_pos   = r_j;
                            n_index = w_j_up;
                            if (r_op == OP_SEARCH) begin
                                n_state = S_LO;
                            end else if (w_last) begin
                                n_count = w_cnt_m1;
                                n_state = S_LO;
                            end
                        end else if (w_last) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_LO;
                        end
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = w_j_dn[AW-1:0];
                        o_mem_wdata = i_mem_rdata;
                        if (w_last) begin
                            n_count = w_cnt_m1;
                            n_state = S_LO;
                        end
                    end
                end
            end

            S_LO: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = '0;
                n_state     = S_HI;
            end

            S_HI: begin
                n_lo        = i_mem_rdata;
                o_mem_re    = 1'b1;
                o_mem_raddr = w_cnt_m1[AW-1:0];
                n_state     = S_CAP;
            end

            S_CAP: begin
                n_hi    = i_mem_rdata;
                n_state = S_OUT;
            end

            S_OUT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_k      <= n_k;
        r_more   <= n_more;
        r_pend   <= n_pend;
        r_j      <= n_j;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_index  <= n_index;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
    end

    assign w_lo_ext  = {{32{r_lo[EW-1]}}, r_lo};
    assign w_hi_ext  = {{32{r_hi[EW-1]}}, r_hi};
    assign w_idx_ext = {8'd0, r_index};
    assign w_cnt_ext = {8'd0, r_count};

    assign o_res_valid       = (r_state == S_OUT);
    assign o_res.status      = r_status;
    assign o_res.found_index = w_idx_ext[7:0];
    assign o_res.fill_count  = w_cnt_ext[7:0];
    assign o_res.smallest    = (r_count == '0) ? 32'sd0 : w_lo_ext[31:0];
    assign o_res.largest     = (r_count == '0) ? 32'sd0 : w_hi_ext[31:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ste_checker.sv =====
// Port-level checks for the sorted table engine, bound to the top level.
// Depends on ste_pkg and sorted_table_engine_unit_defines.svh.
`default_nettype none
`include "sorted_table_engine_unit_defines.svh"

module ste_checker
    import ste_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic [1:0]         i_op,
    input wire logic signed [31:0] i_value,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [1:0]         o_status,
    input wire logic [7:0]         o_found_index,
    input wire logic [7:0]         o_fill_count,
    input wire logic signed [31:0] o_smallest,
    input wire logic signed [31:0] o_largest
);

    logic        w_stall;
    logic        w_fail;
    logic [81:0] w_out_bus;
    logic        w_cap_ok;
    logic        w_empty_ok;

    assign w_stall    = o_valid && !i_ready;
    assign w_fail     = o_valid && (o_status != ST_DONE);
    assign w_out_bus  = {o_status, o_found_index, o_fill_count, o_smallest, o_largest};
    assign w_cap_ok   = (CAPACITY > 255) || (32'(o_fill_count) <= 32'(CAPACITY));
    assign w_empty_ok = (o_fill_count != 8'd0)
                        || ((o_smallest == 32'sd0) && (o_largest == 32'sd0));

    // result beat holds while stalled
    `STE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_valid && $stable(w_out_bus))
    // any failed request reports no position
    `STE_ASSERT_NOW(a_fail_no_index, i_clk, i_rst_n, w_fail, o_found_index == 8'd0)
    // fill count stays within the table
    `STE_ASSERT_NOW(a_fill_in_range, i_clk, i_rst_n, o_valid, w_cap_ok)
    // empty table reads zero at both ends
    `STE_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_valid, w_empty_ok)

    logic w_unused;
    assign w_unused = i_valid ^ o_ready ^ (^i_op) ^ (^i_value);

endmodule

bind sorted_table_engine_unit ste_checker #(.CAPACITY(CAPACITY)) u_ste_checker (.*);

`default_nettype wire
